// ----- hw/rtl/rbm_pkg.sv -----
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants of the radial brush mask generator.
// ----------------------------------------------------------------------------
package rbm_pkg;

    localparam int MASK_SIZE_DEF = 64;
    localparam int PIX_W         = 6;
    localparam int ALPHA_W       = 8;
    localparam int SOFT_W        = 17;
    localparam int U_W           = 17;
    localparam int DIV_STEPS     = 16;
    localparam int CFG_SETTLE    = 3;

    localparam logic [SOFT_W-1:0]  SOFT_ONE   = 17'd65536;
    localparam logic [SOFT_W-1:0]  SOFT_RESET = 17'd32768;
    localparam logic [SOFT_W-1:0]  HARD_LIMIT = 17'd656;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 8'd255;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FULL,
        MODE_HARD,
        MODE_SOFT
    } mode_t;

    // Pipeline control shared by the stage chains.
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

// ----- hw/rtl/rbm_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// rbm_sqrt_pipe
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rbm_sqrt_pipe #(
    parameter int VW  = 28,
    parameter int SBW = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rbm_pkg::pipe_ctl_t      ctl,
    input  logic [VW-1:0]           radicand,
    input  logic [SBW-1:0]          side_in,
    output logic                    valid_out,
    output logic [VW/2-1:0]         root,
    output logic [SBW-1:0]          side_out
);
    import rbm_pkg::*;

    localparam int QW = VW / 2;

    logic              vld_reg  [QW];
    logic [QW-1:0]     root_reg [QW];
    logic [QW+1:0]     rem_reg  [QW];
    logic [VW-1:0]     v_reg    [QW];
    logic [SBW-1:0]    side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic           pv_vld;
        logic [QW-1:0]  pv_root;
        logic [QW+1:0]  pv_rem;
        logic [VW-1:0]  pv_v;
        logic [SBW-1:0] pv_side;
        logic [QW+1:0]  trial;
        logic [QW+1:0]  cur;
        logic           ge;
        logic [QW-1:0]  root_next;
        logic [QW+1:0]  rem_next;

        if (i == 0) begin : g_first
            assign pv_vld  = ctl.valid;
            assign pv_root = '0;
            assign pv_rem  = '0;
            assign pv_v    = radicand;
            assign pv_side = side_in;
        end
        else begin : g_next
            assign pv_vld  = vld_reg[i-1];
            assign pv_root = root_reg[i-1];
            assign pv_rem  = rem_reg[i-1];
            assign pv_v    = v_reg[i-1];
            assign pv_side = side_reg[i-1];
        end

        always_comb
        begin
            cur       = {pv_rem[QW-1:0], pv_v[VW-1 -: 2]};
            trial     = {pv_root, 2'b01};
            ge        = (cur >= trial);
            rem_next  = ge ? (cur - trial) : cur;
            root_next = {pv_root[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                vld_reg[i] <= pv_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                root_reg[i] <= root_next;
                rem_reg[i]  <= rem_next;
                v_reg[i]    <= {pv_v[VW-3:0], 2'b00};
                side_reg[i] <= pv_side;
            end
        end
    end

    assign valid_out = vld_reg[QW-1];
    assign root      = root_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ----- hw/rtl/rbm_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rbm_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rbm_div_pipe #(
    parameter int PW    = 25,
    parameter int QBITS = 16,
    parameter int SBW   = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbm_pkg::pipe_ctl_t   ctl,
    input  logic [PW-1:0]        partial,
    input  logic [PW-1:0]        divisor,
    input  logic [SBW-1:0]       side_in,
    output logic                 valid_out,
    output logic [QBITS-1:0]     quotient,
    output logic [SBW-1:0]       side_out
);
    import rbm_pkg::*;

    logic              vld_reg  [QBITS];
    logic [PW-1:0]     p_reg    [QBITS];
    logic [QBITS-1:0]  q_reg    [QBITS];
    logic [SBW-1:0]    side_reg [QBITS];

    for (genvar i = 0; i < QBITS; i++) begin : g_stage
        logic             pv_vld;
        logic [PW-1:0]    pv_p;
        logic [QBITS-1:0] pv_q;
        logic [SBW-1:0]   pv_side;
        logic [PW-1:0]    p2;
        logic             ge;

        if (i == 0) begin : g_first
            assign pv_vld  = ctl.valid;
            assign pv_p    = partial;
            assign pv_q    = '0;
            assign pv_side = side_in;
        end
        else begin : g_next
            assign pv_vld  = vld_reg[i-1];
            assign pv_p    = p_reg[i-1];
            assign pv_q    = q_reg[i-1];
            assign pv_side = side_reg[i-1];
        end

        // The dividend has only zeros below the starting partial remainder.
        assign p2 = {pv_p[PW-2:0], 1'b0};
        assign ge = (p2 >= divisor);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                vld_reg[i] <= pv_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                p_reg[i]    <= ge ? (p2 - divisor) : p2;
                q_reg[i]    <= {pv_q[QBITS-2:0], ge};
                side_reg[i] <= pv_side;
            end
        end
    end

    assign valid_out = vld_reg[QBITS-1];
    assign quotient  = q_reg[QBITS-1];
    assign side_out  = side_reg[QBITS-1];

endmodule

// ----- hw/rtl/radial_brush_mask.sv -----
// ----------------------------------------------------------------------------
// radial_brush_mask
// Alpha byte of a round brush mask with hard edge or cubic falloff.
// ----------------------------------------------------------------------------
// One pixel is accepted in every cycle while in_ready is high. The square
// root resolves one distance bit per stage, and the divider for the falloff
// resolves one of its 16 quotient bits per stage; an output stall holds the
// whole pipeline. After reset and after every softness write, in_ready stays
// low while the derived softness terms settle.
// ----------------------------------------------------------------------------
module radial_brush_mask #(
    parameter int MASK_SIZE = rbm_pkg::MASK_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rbm_pkg::PIX_W-1:0]   pixel_x,
    input  logic [rbm_pkg::PIX_W-1:0]   pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rbm_pkg::ALPHA_W-1:0] alpha,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rbm_pkg::SOFT_W-1:0]  softness
);
    import rbm_pkg::*;

    localparam int LN    = $clog2(MASK_SIZE) + 1;
    localparam int DW    = LN + 7;
    localparam int SQW   = 2 * DW;
    localparam int D2W   = 2 * LN;
    localparam int VW    = D2W + 14;
    localparam int QW    = VW / 2;
    localparam int NSW   = LN + 17;
    localparam int PW    = NSW + 1;
    localparam int LIMW  = 2 * NSW - 32;
    localparam int CW    = (SQW > LIMW) ? SQW : LIMW;
    localparam int SBW   = 2 + ALPHA_W + 1;
    localparam int U2W   = 2 * U_W;
    localparam int U3W   = 3 * U_W;
    localparam int U3SW  = U3W - 24;

    localparam logic signed [DW-1:0] CTR2      = DW'(MASK_SIZE - 1);
    localparam logic [SQW-1:0]       OUT_LIM   = SQW'(MASK_SIZE * MASK_SIZE);
    localparam logic [SQW-1:0]       HARD_CORE = SQW'((MASK_SIZE - 2) * (MASK_SIZE - 2));
    localparam logic [QW-1:0]        R8        = QW'(MASK_SIZE * 128);
    localparam logic [U_W-1:0]       U_ONE     = U_W'(65536);

    // ------------------------------------------------------------------
    // Softness register and its derived terms.
    // ------------------------------------------------------------------
    logic [SOFT_W-1:0] soft_reg;
    logic [1:0]        busy_reg;
    logic [SOFT_W-1:0] s_sat_reg;
    logic [NSW-1:0]    ns_reg;
    logic [NSW-1:0]    core_reg;
    logic              hard_reg;
    logic [LIMW-1:0]   lim_reg;
    logic [2*NSW-1:0]  core_sq;

    assign cfg_ready = (busy_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_reg <= SOFT_RESET;
            busy_reg <= 2'(CFG_SETTLE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            soft_reg <= softness;
            busy_reg <= 2'(CFG_SETTLE);
        end
        else if (busy_reg != 2'd0)
        begin
            busy_reg <= busy_reg - 2'd1;
        end
    end

    assign core_sq = (2*NSW)'(core_reg) * (2*NSW)'(core_reg);

    always_ff @(posedge clk)
    begin
        s_sat_reg <= (soft_reg > SOFT_ONE) ? SOFT_ONE : soft_reg;
        hard_reg  <= (s_sat_reg < HARD_LIMIT);
        ns_reg    <= NSW'(MASK_SIZE) * NSW'(s_sat_reg);
        core_reg  <= NSW'(MASK_SIZE) * NSW'(SOFT_ONE - s_sat_reg);
        lim_reg   <= core_sq[2*NSW-1:32];
    end

    // ------------------------------------------------------------------
    // Pipeline flow control.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic advance;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance && (busy_reg == 2'd0);

    // Stage A: squared doubled distance from the centre.
    logic                  a_valid_reg;
    logic [SQW-1:0]        a_d2_reg;
    logic signed [DW-1:0]  dx2;
    logic signed [DW-1:0]  dy2;
    logic signed [SQW-1:0] sx;
    logic signed [SQW-1:0] sy;

    assign dx2 = $signed(DW'({pixel_x, 1'b0})) - CTR2;
    assign dy2 = $signed(DW'({pixel_y, 1'b0})) - CTR2;
    assign sx  = SQW'(dx2);
    assign sy  = SQW'(dy2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_d2_reg <= $unsigned(sx * sx + sy * sy);
        end
    end

    // Stage B: region decision and square root operand.
    logic           b_valid_reg;
    mode_t          b_mode_reg;
    logic [VW-1:0]  b_v_reg;
    mode_t          b_mode_next;

    always_comb
    begin
        if (a_d2_reg > OUT_LIM)
        begin
            b_mode_next = MODE_ZERO;
        end
        else if (hard_reg)
        begin
            b_mode_next = (a_d2_reg <= HARD_CORE) ? MODE_FULL : MODE_HARD;
        end
        else
        begin
            b_mode_next = (CW'(a_d2_reg) <= CW'(lim_reg)) ? MODE_FULL : MODE_SOFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_mode_reg <= b_mode_next;
            b_v_reg    <= {a_d2_reg[D2W-1:0], 14'd0};
        end
    end

    // Distance with eight fraction bits.
    pipe_ctl_t     sq_ctl;
    logic          sq_valid;
    logic [QW-1:0] sq_root;
    logic [1:0]    sq_side;

    assign sq_ctl.advance = advance;
    assign sq_ctl.valid   = b_valid_reg;

    rbm_sqrt_pipe #(
        .VW  (VW),
        .SBW (2)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .radicand  (b_v_reg),
        .side_in   (b_mode_reg),
        .valid_out (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // Stage C: distance to the rim, hard edge alpha and divider set-up.
    logic               c_valid_reg;
    logic [SBW-1:0]     c_side_reg;
    logic [PW-1:0]      c_p_reg;
    logic [QW-1:0]      rim;
    logic [QW+7:0]      ham;
    logic [QW-1:0]      ha_w;
    logic [ALPHA_W-1:0] ha;
    logic [PW-1:0]      p0;
    logic               sat;

    always_comb
    begin
        rim  = (sq_root >= R8) ? '0 : (R8 - sq_root);
        ham  = {rim, 8'd0} - (QW+8)'(rim);
        ha_w = ham[QW+7:8];
        ha   = (ha_w > QW'(ALPHA_MAX)) ? ALPHA_MAX : ha_w[ALPHA_W-1:0];
        p0   = PW'({rim, 9'd0});
        sat  = (p0 >= PW'(ns_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_side_reg <= {sq_side, ha, sat};
            c_p_reg    <= p0;
        end
    end

    // Falloff u = 1 - t in Q16.
    pipe_ctl_t            dv_ctl;
    logic                 dv_valid;
    logic [DIV_STEPS-1:0] dv_q;
    logic [SBW-1:0]       dv_side;

    assign dv_ctl.advance = advance;
    assign dv_ctl.valid   = c_valid_reg;

    rbm_div_pipe #(
        .PW    (PW),
        .QBITS (DIV_STEPS),
        .SBW   (SBW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dv_ctl),
        .partial   (c_p_reg),
        .divisor   (PW'(ns_reg)),
        .side_in   (c_side_reg),
        .valid_out (dv_valid),
        .quotient  (dv_q),
        .side_out  (dv_side)
    );

    // Stages D to F: saturate u, then cube it.
    logic               d_valid_reg;
    mode_t              d_mode_reg;
    logic [ALPHA_W-1:0] d_ha_reg;
    logic [U_W-1:0]     d_u_reg;
    logic               e_valid_reg;
    mode_t              e_mode_reg;
    logic [ALPHA_W-1:0] e_ha_reg;
    logic [U_W-1:0]     e_u_reg;
    logic [U2W-1:0]     e_u2_reg;
    logic               f_valid_reg;
    mode_t              f_mode_reg;
    logic [ALPHA_W-1:0] f_ha_reg;
    logic [U3SW-1:0]    f_u3_reg;
    logic [U3W-1:0]     u3_full;

    assign u3_full = U3W'(e_u2_reg) * U3W'(e_u_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            d_valid_reg <= dv_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_mode_reg <= mode_t'(dv_side[SBW-1 -: 2]);
            d_ha_reg   <= dv_side[ALPHA_W:1];
            d_u_reg    <= dv_side[0] ? U_ONE : U_W'(dv_q);
            e_mode_reg <= d_mode_reg;
            e_ha_reg   <= d_ha_reg;
            e_u_reg    <= d_u_reg;
            e_u2_reg   <= U2W'(d_u_reg) * U2W'(d_u_reg);
            f_mode_reg <= e_mode_reg;
            f_ha_reg   <= e_ha_reg;
            f_u3_reg   <= u3_full[U3W-1:24];
        end
    end

    // Stage G: output register.
    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] alpha_next;
    logic [U3SW+7:0]    sm;
    logic [U3SW-17:0]   sm_hi;
    logic [ALPHA_W-1:0] soft_alpha;

    always_comb
    begin
        sm         = {f_u3_reg, 8'd0} - (U3SW+8)'(f_u3_reg);
        sm_hi      = sm[U3SW+7:24];
        soft_alpha = (sm_hi > (U3SW-16)'(ALPHA_MAX)) ? ALPHA_MAX : sm_hi[ALPHA_W-1:0];
        case (f_mode_reg)
            MODE_ZERO: alpha_next = '0;
            MODE_FULL: alpha_next = ALPHA_MAX;
            MODE_HARD: alpha_next = f_ha_reg;
            MODE_SOFT: alpha_next = soft_alpha;
            default:   alpha_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            alpha_reg <= alpha_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign alpha     = alpha_reg;

endmodule
